FILE: rtl/core/icmp_pkg.sv
package icmp_pkg;

  // Default frame store depth in bytes.
  localparam int MaxFrameDef = 256;

  // Width of the checksum accumulator in the shared adder.
  localparam int AccW = 32;

  // Shortest frame that can carry an echo request.
  localparam int MinFrame = 42;

  // Bytes of the frame that the header registers hold.
  localparam int HdrBytes = 38;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegServerIp  = 2'd0;
  localparam logic [1:0] RegRedirIp   = 2'd1;
  localparam logic [1:0] RegTraceDist = 2'd2;
  localparam logic [1:0] RegFloodLim  = 2'd3;

  // Register reset values.
  localparam logic [31:0] ServerIpRst  = 32'hC0A8_0170;
  localparam logic [31:0] RedirIpRst   = 32'h0808_0808;
  localparam logic [4:0]  TraceDistRst = 5'd0;
  localparam logic [7:0]  FloodLimRst  = 8'd10;

  // Operation codes of an input item.
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // ICMP types written into the reply.
  localparam logic [3:0] TypeEchoReply = 4'd0;
  localparam logic [3:0] TypeUnreach   = 4'd3;
  localparam logic [3:0] TypeQuench    = 4'd4;
  localparam logic [3:0] TypeRedirect  = 4'd5;
  localparam logic [3:0] TypeTimeExc   = 4'd11;
  localparam logic [3:0] TypeParamProb = 4'd12;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  byte_count;
    logic [3:0]  reply_type;
    logic        end_of_frame;
  } out_t;

  typedef struct packed {
    logic [31:0] server_ip;
    logic [31:0] redirect_ip;
    logic [4:0]  trace_distance;
    logic [7:0]  flood_limit;
  } cfg_t;

  // Control of the shared checksum adder.
  typedef struct packed {
    logic clr;
    logic add;
  } csum_ctl_t;

endpackage

FILE: rtl/core/icmp_csum.sv
module icmp_csum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  icmp_pkg::csum_ctl_t   ctl_i,
  input  logic [3:0][15:0]      words_i,
  output logic [15:0]           sum_o
);

  logic [icmp_pkg::AccW-1:0] acc_q, acc_d;
  logic [icmp_pkg::AccW-1:0] fold1, fold2;

  // Accumulate up to four 16-bit words per step.
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + icmp_pkg::AccW'(words_i[0]) + icmp_pkg::AccW'(words_i[1])
                    + icmp_pkg::AccW'(words_i[2]) + icmp_pkg::AccW'(words_i[3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Fold the carries back in and complement.
  assign fold1 = (acc_q >> 16) + icmp_pkg::AccW'(acc_q[15:0]);
  assign fold2 = fold1 + (fold1 >> 16);
  assign sum_o = ~fold2[15:0];

endmodule

FILE: rtl/core/icmp_regs.sv
module icmp_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output icmp_pkg::cfg_t    cfg_o
);

  icmp_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes on the access phase of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.server_ip      <= icmp_pkg::ServerIpRst;
      cfg_q.redirect_ip    <= icmp_pkg::RedirIpRst;
      cfg_q.trace_distance <= icmp_pkg::TraceDistRst;
      cfg_q.flood_limit    <= icmp_pkg::FloodLimRst;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        icmp_pkg::RegServerIp:  cfg_q.server_ip      <= pwdata;
        icmp_pkg::RegRedirIp:   cfg_q.redirect_ip    <= pwdata;
        icmp_pkg::RegTraceDist: cfg_q.trace_distance <= pwdata[4:0];
        icmp_pkg::RegFloodLim:  cfg_q.flood_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[3:2])
      icmp_pkg::RegServerIp:  prdata = cfg_q.server_ip;
      icmp_pkg::RegRedirIp:   prdata = cfg_q.redirect_ip;
      icmp_pkg::RegTraceDist: prdata = {27'd0, cfg_q.trace_distance};
      icmp_pkg::RegFloodLim:  prdata = {24'd0, cfg_q.flood_limit};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/icmp_echo_responder.sv
// Channel   | Signals                         | Transfer
// ----------+---------------------------------+-----------------------------------
// input     | start, busy, in_i               | start high while busy is low
// result    | res_valid_o, res_o              | every cycle res_valid_o is high
// config    | psel, penable, pwrite, paddr,   | psel, penable, pwrite, pready high
//           | pwdata, prdata, pready          |
//
// While the frame is collected, a frame byte or a tick is accepted whenever busy is low.
// After the last byte the sequencer runs the decide state, IP header sum and fold,
// a read and an add per 8-byte row of ICMP sum and a fold, and a read and an output
// per reply word, which the shared checksum adder and single memory read port set.
// Reset is asynchronous and clears the control state; the memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module icmp_echo_responder #(
  parameter int MAX_FRAME = icmp_pkg::MaxFrameDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  icmp_pkg::in_t     in_i,
  output logic              res_valid_o,
  output icmp_pkg::out_t    res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LEN_W = $clog2(MAX_FRAME + 1);
  localparam int ROWS  = (MAX_FRAME + 7) / 8;
  localparam int ROW_W = $clog2(ROWS);
  localparam int OFF_W = LEN_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_IPSUM, S_IPFOLD, S_ICRD, S_ICADD, S_ICFOLD, S_EMRD, S_EMOUT
  } state_e;

  icmp_pkg::cfg_t      cfg;
  icmp_pkg::csum_ctl_t csum_ctl;
  logic [3:0][15:0]    csum_words;
  logic [15:0]         csum_sum;

  state_e            state_q;
  logic [LEN_W-1:0]  len_q, end_q;
  logic [ROW_W-1:0]  row_q, last_ic_q, last_em_q;
  logic [1:0]        step_q;
  logic              win_q, trace_q, code_q;
  logic [7:0]        fc_q;
  logic [3:0]        type_q;
  logic [15:0]       ipsum_q, icsum_q;
  logic [7:0]        hdr_q [icmp_pkg::HdrBytes];
  logic [63:0]       mem [ROWS];
  logic [63:0]       rd_q;

  logic accept, store_ok;

  icmp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  icmp_csum u_csum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (csum_ctl),
    .words_i (csum_words),
    .sum_o   (csum_sum)
  );

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign store_ok = accept && (in_i.op == icmp_pkg::OpByte) && (len_q < LEN_W'(MAX_FRAME));

  // Frame memory: one byte lane written per byte, one row read in each read state.
  always_ff @(posedge clk_i) begin
    if (store_ok) begin
      mem[len_q[3 +: ROW_W]][8*(7 - int'(len_q[2:0])) +: 8] <= in_i.data_byte;
    end
    if (state_q == S_ICRD || state_q == S_EMRD) begin
      rd_q <= mem[row_q];
    end
  end

  // Header bytes kept in registers for the checks and rewrites.
  always_ff @(posedge clk_i) begin
    if (store_ok && len_q < LEN_W'(icmp_pkg::HdrBytes)) begin
      hdr_q[len_q[5:0]] <= in_i.data_byte;
    end
  end

  // Decision on the stored header.
  logic              frame_ok, param_bad, ttl_low;
  logic [7:0]        ttl, fc_inc;
  logic [31:0]       dst;
  logic [15:0]       total;
  logic [16:0]       tot_end;
  logic [LEN_W-1:0]  end_n, end_m1, len_m1;
  logic [3:0]        type_n;
  logic              code_n, trace_n;

  always_comb begin
    ttl       = hdr_q[22];
    dst       = {hdr_q[30], hdr_q[31], hdr_q[32], hdr_q[33]};
    frame_ok  = (len_q >= LEN_W'(icmp_pkg::MinFrame)) && (hdr_q[12] == 8'h08) &&
                (hdr_q[13] == 8'h00) && (hdr_q[23] == 8'h01) && (hdr_q[34] == 8'h08);
    param_bad = (hdr_q[14] != 8'h45);
    ttl_low   = (ttl <= 8'd1);
    fc_inc    = (fc_q == 8'hFF) ? fc_q : fc_q + 8'd1;
    type_n    = icmp_pkg::TypeEchoReply;
    code_n    = 1'b0;
    trace_n   = 1'b0;
    if (param_bad) begin
      type_n = icmp_pkg::TypeParamProb;
    end else if (ttl_low) begin
      type_n = icmp_pkg::TypeTimeExc;
    end else if (win_q && fc_inc > cfg.flood_limit) begin
      type_n = icmp_pkg::TypeQuench;
    end
    if (type_n == icmp_pkg::TypeEchoReply && dst != cfg.server_ip) begin
      type_n = (dst == cfg.redirect_ip) ? icmp_pkg::TypeRedirect : icmp_pkg::TypeUnreach;
      code_n = 1'b1;
    end
    if (ttl >= 8'd1 && ttl <= {3'd0, cfg.trace_distance}) begin
      type_n  = icmp_pkg::TypeTimeExc;
      code_n  = 1'b0;
      trace_n = 1'b1;
    end
    // The ICMP sum ends at the IP total length when that is at least 28 and fits the frame.
    total   = {hdr_q[16], hdr_q[17]};
    tot_end = {1'b0, total} + 17'd14;
    end_n   = (total >= 16'd28 && tot_end <= 17'(len_q)) ? LEN_W'(tot_end) : len_q;
    end_m1  = end_n - LEN_W'(1);
    len_m1  = len_q - LEN_W'(1);
  end

  // Rewritten header.
  logic [7:0]  nh [40];
  logic [31:0] src;

  always_comb begin
    src = trace_q ? {8'h0A, 16'h0000, hdr_q[22]} : cfg.server_ip;
    for (int i = 0; i < icmp_pkg::HdrBytes; i++) begin
      nh[i] = hdr_q[i];
    end
    nh[38] = 8'h00;
    nh[39] = 8'h00;
    for (int i = 0; i < 6; i++) begin
      nh[i]     = hdr_q[i + 6];
      nh[i + 6] = hdr_q[i];
    end
    for (int i = 0; i < 4; i++) begin
      nh[26 + i] = src[8*(3 - i) +: 8];
      nh[30 + i] = hdr_q[26 + i];
    end
    nh[24] = ipsum_q[15:8];
    nh[25] = ipsum_q[7:0];
    nh[34] = {4'd0, type_q};
    nh[35] = {7'd0, code_q};
    nh[36] = icsum_q[15:8];
    nh[37] = icsum_q[7:0];
  end

  // Operands for the shared adder.
  logic [OFF_W-1:0] base, off;
  logic [7:0]       hi_b, lo_b;
  logic             row4;

  always_comb begin
    base       = OFF_W'({row_q, 3'b000});
    row4       = (row_q == ROW_W'(4));
    csum_words = '0;
    csum_ctl   = '0;
    hi_b       = '0;
    lo_b       = '0;
    off        = '0;
    unique case (state_q)
      S_DECIDE, S_IPFOLD: begin
        csum_ctl.clr = 1'b1;
      end
      S_IPSUM: begin
        csum_ctl.add = 1'b1;
        case (step_q)
          2'd0: csum_words = {{nh[14], nh[15]}, {nh[16], nh[17]},
                              {nh[18], nh[19]}, {nh[20], nh[21]}};
          2'd1: csum_words = {{nh[22], nh[23]}, 16'h0000,
                              {nh[26], nh[27]}, {nh[28], nh[29]}};
          default: csum_words = {{nh[30], nh[31]}, {nh[32], nh[33]}, 16'h0000, 16'h0000};
        endcase
      end
      S_ICADD: begin
        csum_ctl.add = 1'b1;
        for (int k = 0; k < 4; k++) begin
          off  = base + OFF_W'(2 * k);
          hi_b = rd_q[63 - 16*k -: 8];
          lo_b = rd_q[55 - 16*k -: 8];
          if (row4 && k == 1) begin
            hi_b = {4'd0, type_q};
            lo_b = {7'd0, code_q};
          end else if (row4 && k == 2) begin
            hi_b = 8'h00;
            lo_b = 8'h00;
          end
          if (!(off >= OFF_W'(34) && off < OFF_W'(end_q))) begin
            hi_b = 8'h00;
          end
          if (!(off >= OFF_W'(34) && off + OFF_W'(1) < OFF_W'(end_q))) begin
            lo_b = 8'h00;
          end
          csum_words[3 - k] = {hi_b, lo_b};
        end
      end
      default: ;
    endcase
  end

  // Reply word assembly.
  logic [OFF_W-1:0] eoff, rem;

  always_comb begin
    res_valid_o       = (state_q == S_EMOUT);
    res_o.word        = '0;
    res_o.reply_type  = type_q;
    rem               = OFF_W'(len_q) - base;
    res_o.byte_count  = (rem >= OFF_W'(8)) ? 4'd8 : rem[3:0];
    res_o.end_of_frame = (base + OFF_W'(8) >= OFF_W'(len_q));
    eoff              = '0;
    for (int k = 0; k < 8; k++) begin
      eoff = base + OFF_W'(k);
      if (eoff < OFF_W'(len_q)) begin
        if (eoff < OFF_W'(icmp_pkg::HdrBytes)) begin
          res_o.word[63 - 8*k -: 8] = nh[{row_q[2:0], 3'(k)}];
        end else begin
          res_o.word[63 - 8*k -: 8] = rd_q[63 - 8*k -: 8];
        end
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      end_q     <= '0;
      row_q     <= '0;
      last_ic_q <= '0;
      last_em_q <= '0;
      step_q    <= '0;
      win_q     <= 1'b0;
      fc_q      <= '0;
      trace_q   <= 1'b0;
      code_q    <= 1'b0;
      type_q    <= icmp_pkg::TypeEchoReply;
      ipsum_q   <= '0;
      icsum_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_i.op == icmp_pkg::OpTick) begin
              win_q <= 1'b0;
            end else begin
              if (store_ok) begin
                len_q <= len_q + LEN_W'(1);
              end
              if (in_i.last) begin
                state_q <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          if (!frame_ok) begin
            len_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            if (!param_bad && !ttl_low) begin
              if (win_q) begin
                fc_q <= fc_inc;
              end else begin
                win_q <= 1'b1;
                fc_q  <= '0;
              end
            end
            type_q    <= type_n;
            code_q    <= code_n;
            trace_q   <= trace_n;
            ipsum_q   <= '0;
            icsum_q   <= '0;
            end_q     <= end_n;
            last_ic_q <= ROW_W'(end_m1 >> 3);
            last_em_q <= ROW_W'(len_m1 >> 3);
            step_q    <= '0;
            state_q   <= S_IPSUM;
          end
        end
        S_IPSUM: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd2) begin
            state_q <= S_IPFOLD;
          end
        end
        S_IPFOLD: begin
          ipsum_q <= csum_sum;
          row_q   <= ROW_W'(4);
          state_q <= S_ICRD;
        end
        S_ICRD: begin
          state_q <= S_ICADD;
        end
        S_ICADD: begin
          if (row_q == last_ic_q) begin
            state_q <= S_ICFOLD;
          end else begin
            row_q   <= row_q + ROW_W'(1);
            state_q <= S_ICRD;
          end
        end
        S_ICFOLD: begin
          icsum_q <= csum_sum;
          row_q   <= '0;
          state_q <= S_EMRD;
        end
        S_EMRD: begin
          state_q <= S_EMOUT;
        end
        S_EMOUT: begin
          if (row_q == last_em_q) begin
            len_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            row_q   <= row_q + ROW_W'(1);
            state_q <= S_EMRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/icmp_checker.sv
module icmp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input icmp_pkg::in_t  in_i,
  input logic           res_valid_o,
  input icmp_pkg::out_t res_o
);

  // Results only appear while the block is working on a frame.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result shown while not busy");

  // Reply words never come back to back.
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("back-to-back reply words");

  // The last word of a reply ends the work on that frame.
  a_eof_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.end_of_frame) |=> !busy) else $error("busy after end of frame");

  // A word carries one to eight bytes.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.byte_count != 4'd0 && res_o.byte_count <= 4'd8))
    else $error("byte count out of range");

  // The final byte of a frame starts the reply work.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.op == icmp_pkg::OpByte && in_i.last) |=> busy)
    else $error("frame end not processed");

endmodule

bind icmp_echo_responder icmp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .in_i        (in_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
